[rtl/sitda_pkg.sv]
// sitda_pkg: shared widths, character codes and a status struct for the
// signed integer to decimal ascii converter; no dependencies
package sitda_pkg;

    localparam int VALUE_BITS = 64;                      // bits of value taken, 8 to 64
    localparam int VALUE_W    = 64;                      // width of the value field
    localparam int CHAR_W     = 6;                       // width of char_code
    localparam int NDIG       = ((VALUE_BITS * 1233) >> 12) + 1;  // decimal digits needed
    localparam int BCD_W      = NDIG * 4;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int LEFT_W     = $clog2(NDIG + 1);

    localparam logic [CHAR_W-1:0] CODE_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CODE_NINE  = CHAR_W'(57);
    localparam logic [CHAR_W-1:0] CODE_MINUS = CHAR_W'(45);

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

[rtl/sitda_if.sv]
// sitda_if: valid/ready channel interfaces for value in and characters out
// depends on sitda_pkg
interface sitda_in_if import sitda_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if import sitda_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

[rtl/sitda_bcd.sv]
// sitda_bcd: bit-serial binary to bcd converter (shift and add-3)
// depends on sitda_pkg
module sitda_bcd import sitda_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_mag,
    output logic [BCD_W-1:0]      o_bcd,
    output t_unit_stat            o_stat
);

    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [BCD_W-1:0]      adj;

    // add 3 to every digit of 5 or more, each digit its own lane
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ? r_bcd[d*4 +: 4] + 4'd3
                                                      : r_bcd[d*4 +: 4];
        end
    end

    always_comb begin
        n_mag  = r_mag;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        priority if (i_start) begin
            n_mag  = i_mag;
            n_bcd  = '0;
            n_cnt  = CNT_W'(VALUE_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {adj[BCD_W-2:0], r_mag[VALUE_BITS-1]};
            n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else begin
            // idle, hold
            n_busy = r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_bcd       = r_bcd;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("bcd done without a conversion in progress");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0) && (r_cnt <= CNT_W'(VALUE_BITS)))
        else $error("bcd bit counter out of range");

endmodule

[rtl/sitda_emit.sv]
// sitda_emit: emits sign and digits one character per cycle unless stalled,
// skipping leading zeros, via a registered output; depends on sitda_pkg, sitda_if
module sitda_emit import sitda_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_neg,
    input  logic [BCD_W-1:0] i_bcd,
    sitda_out_if.source      o_out,
    output t_unit_stat       o_stat
);

    logic [BCD_W-1:0]  r_dig, n_dig;
    logic [LEFT_W-1:0] r_left, n_left;
    logic              r_neg, n_neg;
    logic              r_seen, n_seen;
    logic              r_act, n_act;
    logic              r_ov, n_ov;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_last, n_last;
    logic              slot_free;
    logic              out_xfer;
    logic [3:0]        top_dig;

    assign out_xfer  = r_ov && o_out.ready;
    assign slot_free = !r_ov || o_out.ready;
    assign top_dig   = r_dig[BCD_W-1 -: 4];

    always_comb begin
        n_dig  = r_dig;
        n_left = r_left;
        n_neg  = r_neg;
        n_seen = r_seen;
        n_act  = r_act;
        n_ov   = out_xfer ? 1'b0 : r_ov;
        n_char = r_char;
        n_last = r_last;
        priority if (i_start) begin
            n_dig  = i_bcd;
            n_left = LEFT_W'(NDIG);
            n_neg  = i_neg;
            n_seen = 1'b0;
            n_act  = 1'b1;
        end else if (r_act && slot_free) begin
            priority if (r_neg) begin
                n_neg  = 1'b0;
                n_ov   = 1'b1;
                n_char = CODE_MINUS;
                n_last = 1'b0;
            end else if (top_dig == 4'd0 && !r_seen && r_left != LEFT_W'(1)) begin
                // leading zero, drop it
                n_dig  = {r_dig[BCD_W-5:0], 4'd0};
                n_left = r_left - LEFT_W'(1);
            end else begin
                n_dig  = {r_dig[BCD_W-5:0], 4'd0};
                n_left = r_left - LEFT_W'(1);
                n_seen = 1'b1;
                n_ov   = 1'b1;
                n_char = CODE_ZERO + {{(CHAR_W-4){1'b0}}, top_dig};
                n_last = (r_left == LEFT_W'(1));
                n_act  = (r_left != LEFT_W'(1));
            end
        end else begin
            // idle or output stalled, hold
            n_act = r_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig  <= n_dig;
        r_left <= n_left;
        r_neg  <= n_neg;
        r_seen <= n_seen;
        r_char <= n_char;
        r_last <= n_last;
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_act <= n_act;
            r_ov  <= n_ov;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.char_code = r_char;
    assign o_out.last      = r_last;
    assign o_stat.busy     = r_act || r_ov;
    assign o_stat.done     = out_xfer && r_last;

    a_char_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_char == CODE_MINUS) || ((r_char >= CODE_ZERO) && (r_char <= CODE_NINE)))
        else $error("character code outside minus and digits");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_char == CODE_MINUS) |-> !r_last && r_act)
        else $error("minus sign emitted as final character");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_last) |-> !r_act)
        else $error("emitter still active after final character");

endmodule

[rtl/signed_int_to_decimal_ascii_top.sv]
// channel  dir  modport       payload                       transfer when
// i_in     in   sitda_in_if   value[63:0] signed            valid && ready
// o_out    out  sitda_out_if  char_code[5:0], last          valid && ready
//
// one value at a time: a bit-serial shift-and-add-3 conversion of the
// magnitude, then a digit scan that emits one character per cycle unless
// the output stalls or a leading zero is being dropped (NDIG digit slots,
// one more for the minus sign); i_in.ready returns in the cycle after the
// final character transfers
// i_rst_n is synchronous, active low; no clearing pass after reset
// a stalled output holds its character; i_in.ready stays low until the final
// character of the current value has been transferred
//
// top level of the signed integer to decimal ascii converter
// depends on sitda_pkg, sitda_if, sitda_bcd, sitda_emit
module signed_int_to_decimal_ascii_top import sitda_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sitda_in_if.sink    i_in,
    sitda_out_if.source o_out
);

    // one-hot control states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic                  r_neg, n_neg;
    logic                  in_xfer;
    logic [VALUE_BITS-1:0] raw;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [BCD_W-1:0]      bcd;
    t_unit_stat            bcd_stat;
    t_unit_stat            emit_stat;

    // take a new value only when the previous text is fully out
    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;

    // sign and magnitude within VALUE_BITS; the most negative value wraps to
    // 2^(VALUE_BITS-1), which is its exact unsigned magnitude
    assign raw = i_in.value[VALUE_BITS-1:0];
    assign neg = raw[VALUE_BITS-1];
    assign mag = neg ? (~raw + VALUE_BITS'(1)) : raw;

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_CONV;
                    n_neg   = neg;
                end
            end
            S_CONV: begin
                // emitter picks up the bcd digits on the done pulse
                if (bcd_stat.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_stat.done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    sitda_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_mag   (mag),
        .o_bcd   (bcd),
        .o_stat  (bcd_stat)
    );

    sitda_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bcd_stat.done),
        .i_neg   (r_neg),
        .i_bcd   (bcd),
        .o_out   (o_out),
        .o_stat  (emit_stat)
    );

    a_accept_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> !bcd_stat.busy && !emit_stat.busy)
        else $error("value accepted while a conversion is in flight");

    a_conv_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_CONV) && bcd_stat.busy)
        else $error("conversion did not start after accept");

    a_out_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_state == S_EMIT))
        else $error("character presented outside emit phase");

endmodule
